### hdl/spq_pkg.sv
// Package for the sorted priority queue: depth, derived widths, entry layout
// and the result status codes. No dependencies.
package spq_pkg;

  localparam int DEPTH = 16;                   // queue capacity, 2 .. 31
  localparam int AW    = $clog2(DEPTH);        // entry address width
  localparam int CW    = $clog2(DEPTH + 1);    // occupancy counter width

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_SERVE  = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_SERVED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // priority in the high byte, client in the low byte
  typedef struct packed {
    logic [7:0] prio;
    logic [7:0] client;
  } entry_t;

endpackage

### hdl/spq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module spq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/sorted_priority_queue.sv
// Top level of the sorted priority queue: sequencer, counters and result
// register. Depends on spq_pkg and spq_ram.
//
// Bounded queue of DEPTH entries (client byte plus priority number) held in a
// RAM in ascending priority order; entry 0 is the front. Every input beat
// gives exactly one result beat. An insert walks down from the back of the
// queue with one comparator, moving each entry with a larger number up by one
// place, one entry per cycle, and drops the new entry in behind the last entry
// of lower or equal number, so equal priorities leave in arrival order. A
// serve reads the front entry and then shifts the remaining entries down, one
// per cycle through the single RAM port pair. Serving an empty queue or
// inserting into a full one leaves the queue untouched and reports status
// empty or full. in_ready_o is high only in S_IDLE, between items, and rises
// once S_DONE has moved the result into the output register; S_DONE waits
// while that register still holds a result that has not been taken.
// A finished result sits in an output register, so the next item may be
// accepted before that result is taken.
// The entry RAM needs no clearing after reset: only entries below the count
// are ever read.
module sorted_priority_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       kind_i,
  input  logic [7:0] client_i,
  input  logic [7:0] priority_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic [7:0] served_client_o,
  output logic [7:0] served_priority_o,
  output logic [4:0] occupancy_o
);
  import spq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,      // waiting for an item
    S_INS,       // insert walk: compare entry idx, move it up if larger
    S_PUT,       // new entry goes to the front
    S_SRV_HEAD,  // front entry read back
    S_SRV,       // shift remaining entries down
    S_DONE       // result waits for the output register
  } state_e;

  state_e         state_q, state_d;
  logic [CW-1:0]  count_q, count_d;
  logic [AW-1:0]  idx_q, idx_d;
  entry_t         new_q, new_d;        // entry being inserted
  status_e        st_q, st_d;          // pending result
  entry_t         srv_q, srv_d;        // pending served entry

  logic           out_valid_q, out_valid_d;
  status_e        status_q, status_d;
  entry_t         out_ent_q, out_ent_d;
  logic [4:0]     occ_q, occ_d;

  // RAM port control
  logic           we;
  logic [AW-1:0]  waddr;
  entry_t         wdata;
  logic [AW-1:0]  raddr;
  entry_t         rdata;

  spq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    new_d       = new_q;
    st_d        = st_q;
    srv_d       = srv_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    out_ent_d   = out_ent_q;
    occ_d       = occ_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = new_q;
    raddr       = '0;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          new_d = '{prio: priority_req_i, client: client_i};
          srv_d = '0;
          if (kind_i == KIND_INSERT) begin
            if (count_q == CW'(DEPTH)) begin
              st_d    = ST_FULL;
              state_d = S_DONE;
            end else if (count_q == '0) begin
              // empty queue: write straight to the front
              we      = 1'b1;
              waddr   = '0;
              wdata   = '{prio: priority_req_i, client: client_i};
              count_d = count_q + 1'b1;
              st_d    = ST_INSERTED;
              state_d = S_DONE;
            end else begin
              raddr   = AW'(count_q - 1'b1);
              idx_d   = AW'(count_q - 1'b1);
              state_d = S_INS;
            end
          end else begin
            if (count_q == '0) begin
              st_d    = ST_EMPTY;
              state_d = S_DONE;
            end else begin
              raddr   = '0;
              state_d = S_SRV_HEAD;
            end
          end
        end
      end

      S_INS: begin
        we    = 1'b1;
        waddr = idx_q + 1'b1;
        if (rdata.prio > new_q.prio) begin
          // larger number: move it one place back, look at the next one
          wdata = rdata;
          if (idx_q == '0) begin
            state_d = S_PUT;
          end else begin
            idx_d = idx_q - 1'b1;
            raddr = idx_q - 1'b1;
          end
        end else begin
          wdata   = new_q;
          count_d = count_q + 1'b1;
          st_d    = ST_INSERTED;
          state_d = S_DONE;
        end
      end

      S_PUT: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = new_q;
        count_d = count_q + 1'b1;
        st_d    = ST_INSERTED;
        state_d = S_DONE;
      end

      S_SRV_HEAD: begin
        srv_d = rdata;
        if (count_q == CW'(1)) begin
          count_d = count_q - 1'b1;
          st_d    = ST_SERVED;
          state_d = S_DONE;
        end else begin
          idx_d   = AW'(1);
          raddr   = AW'(1);
          state_d = S_SRV;
        end
      end

      S_SRV: begin
        we    = 1'b1;
        waddr = idx_q - 1'b1;
        wdata = rdata;
        if (CW'(idx_q) + 1'b1 == count_q) begin
          count_d = count_q - 1'b1;
          st_d    = ST_SERVED;
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
          raddr = idx_q + 1'b1;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = st_q;
          out_ent_d   = srv_q;
          occ_d       = 5'(count_q);
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    new_q     <= new_d;
    st_q      <= st_d;
    srv_q     <= srv_d;
    status_q  <= status_d;
    out_ent_q <= out_ent_d;
    occ_q     <= occ_d;
  end

  assign in_ready_o        = (state_q == S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign served_client_o   = out_ent_q.client;
  assign served_priority_o = out_ent_q.prio;
  assign occupancy_o       = occ_q;

endmodule

### hdl/spq_checker.sv
// Port-level assertions for the sorted priority queue, bound to the top level.
// Depends on spq_pkg.
module spq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] status_o,
  input logic [7:0] served_client_o,
  input logic [7:0] served_priority_o,
  input logic [4:0] occupancy_o
);
  import spq_pkg::*;

  // one item at a time: no input beat right after one was taken
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted back to back");

  // an empty serve leaves nothing queued and returns zeros
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |->
      served_client_o == 8'd0 && served_priority_o == 8'd0 && occupancy_o == 5'd0)
    else $error("empty result with data or occupancy");

  // a rejected insert means the queue is full
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |->
      occupancy_o == 5'(DEPTH) && served_client_o == 8'd0)
    else $error("full result with wrong occupancy");

  // a stalled result holds its status and occupancy
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(status_o) && $stable(occupancy_o))
    else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

### verif/tb_sorted_priority_queue.sv
// Testbench for sorted_priority_queue: a scoreboard keeps its own sorted copy
// of the queue and checks every result beat in arrival order.
// Depends on spq_pkg and the RTL of the block only.
module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int unsigned N_RANDOM      = 1250;
  localparam int unsigned HOLD_AFTER    = 400;  // result count at which the sink starts its long hold
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 2 * DEPTH + 8;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef struct packed {
    status_e    status;
    logic [7:0] client;
    logic [7:0] prio;
    logic [4:0] occupancy;
  } result_t;

  // Sorted copy of the queue plus the list of result beats still owed.
  class serve_order_scoreboard;
    entry_t      slots[DEPTH];
    int unsigned fill;
    result_t     awaited[$];
    int unsigned mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%0t: %s", $time, what);
    endfunction

    // Apply one accepted input beat to the copy and queue its result.
    function void note_item(logic kind, logic [7:0] client, logic [7:0] prio);
      result_t     r;
      int unsigned pos;
      r = '{status: ST_INSERTED, client: 8'h00, prio: 8'h00, occupancy: 5'd0};
      if (kind == KIND_INSERT) begin
        if (fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // land behind every entry of lower or equal number: ties stay in order
          pos = 0;
          while (pos < fill && slots[pos].prio <= prio) pos++;
          for (int unsigned i = fill; i > pos; i--) slots[i] = slots[i - 1];
          slots[pos] = '{prio: prio, client: client};
          fill++;
        end
      end else if (fill == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.status = ST_SERVED;
        r.client = slots[0].client;
        r.prio   = slots[0].prio;
        for (int unsigned i = 1; i < fill; i++) slots[i - 1] = slots[i];
        fill--;
      end
      r.occupancy = 5'(fill);
      awaited.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic [7:0] client,
                               logic [7:0] prio, logic [4:0] occupancy);
      result_t want;
      if (awaited.size() == 0) begin
        flag($sformatf("unexpected result beat: st=%0d cl=%02h pr=%02h occ=%0d",
                       status, client, prio, occupancy));
        return;
      end
      want = awaited.pop_front();
      if (status !== want.status || client !== want.client ||
          prio !== want.prio || occupancy !== want.occupancy)
        flag($sformatf("exp st=%0d cl=%02h pr=%02h occ=%0d, got st=%0d cl=%02h pr=%02h occ=%0d",
                       want.status, want.client, want.prio, want.occupancy,
                       status, client, prio, occupancy));
    endfunction
  endclass

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_ready_o;
  logic       kind_i         = KIND_INSERT;
  logic [7:0] client_i       = 8'h00;
  logic [7:0] priority_req_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i    = 1'b0;
  logic [1:0] status_o;
  logic [7:0] served_client_o;
  logic [7:0] served_priority_o;
  logic [4:0] occupancy_o;

  serve_order_scoreboard sb = new();
  bit in_burst = 1'b0;  // sender offers back to back while set

  sorted_priority_queue i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .kind_i            (kind_i),
    .client_i          (client_i),
    .priority_req_i    (priority_req_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .served_client_o   (served_client_o),
    .served_priority_o (served_priority_o),
    .occupancy_o       (occupancy_o)
  );

  always #5 clk_i = ~clk_i;

  // Called at a rising edge; returns at the edge the beat is taken. Valid is
  // touched once per step: lowered only when a gap is drawn.
  task automatic send_item(logic kind, logic [7:0] client, logic [7:0] prio);
    int unsigned gap;
    gap = in_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    client_i       <= client;
    priority_req_i <= prio;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(kind, client, prio);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned insert_pct;
    int unsigned prio_mode;
    logic [7:0]  prio;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: serve on empty with the ignored fields set, then fill with
    // extremes and ties, overflow once, and serve part of it back
    send_item(KIND_SERVE, 8'hFF, 8'hFF);
    send_item(KIND_INSERT, 8'hA5, 8'h80);
    send_item(KIND_INSERT, 8'h5A, 8'h80);
    send_item(KIND_INSERT, 8'h00, 8'hFF);
    send_item(KIND_INSERT, 8'hFF, 8'h00);
    send_item(KIND_INSERT, 8'h11, 8'h00);
    for (int unsigned i = 0; i < 11; i++)
      send_item(KIND_INSERT, 8'(8'h20 + i), 8'(i * 23));
    send_item(KIND_INSERT, 8'h77, 8'h10);
    for (int unsigned i = 0; i < 5; i++)
      send_item(KIND_SERVE, 8'(i * 51), 8'(255 - i * 51));
    wait_drained();

    for (int unsigned n = 0; n < N_RANDOM; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 3))
          0:       insert_pct = 20;
          1:       insert_pct = 50;
          2:       insert_pct = 75;
          default: insert_pct = 95;
        endcase
        prio_mode = $urandom_range(0, 2);
        in_burst  = ($urandom_range(0, 3) == 0);
      end
      if (n == N_RANDOM / 2) wait_drained();
      case (prio_mode)
        0:       prio = 8'($urandom_range(0, 255));
        1:       prio = 8'($urandom_range(0, 3));     // dense ties
        default: prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      endcase
      send_item(($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_SERVE,
                8'($urandom_range(0, 255)), prio);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Result sink: random stalls, calm stretches, and one long hold so the
  // block backs up and stalls its input.
  initial begin : result_sink
    int unsigned seen;
    int unsigned stall;
    bit          steady;
    seen   = 0;
    steady = 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (seen % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      stall = steady ? 0 : $urandom_range(0, 7);
      if (seen == HOLD_AFTER) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(status_o, served_client_o, served_priority_o, occupancy_o);
      seen++;
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### files.f
hdl/spq_pkg.sv
hdl/spq_ram.sv
hdl/sorted_priority_queue.sv
hdl/spq_checker.sv
verif/tb_sorted_priority_queue.sv
